@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the cache table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant check failed");

// Check that a condition holds in the same cycle as its trigger
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Check that a condition holds in the cycle after its trigger
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/cti_pkg.sv @@
// Types, constants and helpers shared by the cache table modules
package cti_pkg;

    localparam int PAGES = 1024;
    localparam int USERS = 2;
    localparam int IDX_W = $clog2(PAGES);
    localparam int CNT_W = $clog2(PAGES + 1);
    localparam int OWN_W = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int SUM_W = CNT_W + OWN_W + 1;

    typedef logic [31:0]      word_t;
    typedef logic [1:0]       user_t;
    typedef logic [9:0]       page_t;
    typedef logic [10:0]      ucount_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [OWN_W-1:0] own_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_EVICT  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_HIT      = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_EVICTED  = 3'd3,
        STATUS_NOMATCH  = 3'd4
    } status_t;

    // One request as it arrives on the input channel
    typedef struct packed {
        op_t   op;
        word_t block;
        logic  dirty;
        user_t user;
        word_t atime;
        word_t prize;
    } req_t;

    // One table slot as it sits in the entry memory
    typedef struct packed {
        logic  valid;
        word_t tag;
        logic  dirty;
        own_t  owner;
        word_t ltime;
        word_t prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result as it leaves on the output channel
    typedef struct packed {
        status_t status;
        page_t   page;
        word_t   block;
        logic    dirty;
        user_t   user;
        ucount_t count;
    } result_t;

    // Map a requested user to an owner index; out-of-range users count as user one
    function automatic own_t norm_user(input user_t u);
        if ((u == user_t'(0)) || (int'(u) > USERS))
        begin
            return own_t'(0);
        end
        return own_t'(int'(u) - 1);
    endfunction

    // Map an owner index back to the user number, counted from one
    function automatic user_t own_to_user(input own_t o);
        return user_t'(o) + user_t'(1);
    endfunction

endpackage

@@ rtl/cti_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data
module cti_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/cti_ctrl.sv @@
// Scan sequencer: clears the table, scans it per item, commits the update
`include "assert_macros.svh"

module cti_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cti_pkg::req_t                in_req,
    output logic                         res_valid,
    input  logic                         res_ready,
    output cti_pkg::result_t             res,
    output logic                         rd_en,
    output cti_pkg::idx_t                rd_addr,
    input  logic [cti_pkg::ENTRY_W-1:0]  rd_data,
    output logic                         wr_en,
    output cti_pkg::idx_t                wr_addr,
    output logic [cti_pkg::ENTRY_W-1:0]  wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    cti_pkg::cnt_t      scan_cnt_reg, scan_cnt_next;
    logic               chk_valid_reg, chk_valid_next;
    cti_pkg::idx_t      chk_idx_reg, chk_idx_next;
    cti_pkg::req_t      req_reg, req_next;
    cti_pkg::own_t      own_reg, own_next;
    logic               found_reg, found_next;
    cti_pkg::idx_t      sel_idx_reg, sel_idx_next;
    cti_pkg::entry_t    sel_entry_reg, sel_entry_next;
    logic               free_found_reg, free_found_next;
    cti_pkg::idx_t      free_idx_reg, free_idx_next;
    cti_pkg::cnt_t      free_pages_reg, free_pages_next;
    cti_pkg::cnt_t      user_pages_reg [cti_pkg::USERS];
    cti_pkg::cnt_t      user_pages_next [cti_pkg::USERS];
    cti_pkg::result_t   res_reg, res_next;
    cti_pkg::sum_t      occ_sum;

    cti_pkg::entry_t    rd_entry;

    assign rd_entry  = cti_pkg::entry_t'(rd_data);
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Next-state logic for the clear pass, the scan and the commit
    always_comb
    begin
        cti_pkg::entry_t upd;
        cti_pkg::cnt_t   cnt_tmp;

        upd             = sel_entry_reg;
        cnt_tmp         = '0;
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        req_next        = req_reg;
        own_next        = own_reg;
        found_next      = found_reg;
        sel_idx_next    = sel_idx_reg;
        sel_entry_next  = sel_entry_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_pages_next = free_pages_reg;
        user_pages_next = user_pages_reg;
        res_next        = res_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_cnt_reg[cti_pkg::IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = sel_idx_reg;
        wr_data         = sel_entry_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the memory once, invalidating every slot
                wr_en   = 1'b1;
                wr_addr = scan_cnt_reg[cti_pkg::IDX_W-1:0];
                wr_data = '0;
                if (scan_cnt_reg == cti_pkg::cnt_t'(cti_pkg::PAGES - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + cti_pkg::cnt_t'(1);
                end
            end

            ST_IDLE:
            begin
                // Capture the item and start a fresh scan
                if (in_valid)
                begin
                    req_next        = in_req;
                    own_next        = cti_pkg::norm_user(in_req.user);
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle across the table
                if (scan_cnt_reg != cti_pkg::cnt_t'(cti_pkg::PAGES))
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_cnt_reg[cti_pkg::IDX_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + cti_pkg::cnt_t'(1);
                end
                else if (!chk_valid_reg)
                begin
                    state_next = ST_COMMIT;
                end

                // Check the slot that came back from memory
                if (chk_valid_reg)
                begin
                    if (req_reg.op == cti_pkg::OP_INSERT)
                    begin
                        if (!found_reg && rd_entry.valid && (rd_entry.tag == req_reg.block))
                        begin
                            found_next     = 1'b1;
                            sel_idx_next   = chk_idx_reg;
                            sel_entry_next = rd_entry;
                        end
                        if (!free_found_reg && !rd_entry.valid)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                    else
                    begin
                        // Keep the oldest match; equal times keep the earlier slot
                        if (rd_entry.valid && (rd_entry.prio == req_reg.prize) &&
                            (!found_reg || (rd_entry.ltime < sel_entry_reg.ltime)))
                        begin
                            found_next     = 1'b1;
                            sel_idx_next   = chk_idx_reg;
                            sel_entry_next = rd_entry;
                        end
                    end
                end
            end

            ST_COMMIT:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                if (req_reg.op == cti_pkg::OP_INSERT)
                begin
                    if (found_reg)
                    begin
                        // Refresh the hit slot
                        upd.dirty = sel_entry_reg.dirty | req_reg.dirty;
                        upd.ltime = req_reg.atime;
                        wr_en     = 1'b1;
                        wr_addr   = sel_idx_reg;
                        wr_data   = upd;
                        res_next.status = cti_pkg::STATUS_HIT;
                        res_next.page   = cti_pkg::page_t'(sel_idx_reg);
                        res_next.block  = upd.tag;
                        res_next.dirty  = upd.dirty;
                        res_next.user   = cti_pkg::own_to_user(upd.owner);
                        res_next.count  = cti_pkg::ucount_t'(user_pages_reg[upd.owner]);
                    end
                    else if ((free_pages_reg == '0) || !free_found_reg)
                    begin
                        res_next.status = cti_pkg::STATUS_FULL;
                        res_next.count  = cti_pkg::ucount_t'(user_pages_reg[own_reg]);
                    end
                    else
                    begin
                        // Fill the lowest free slot
                        upd.valid = 1'b1;
                        upd.tag   = req_reg.block;
                        upd.dirty = req_reg.dirty;
                        upd.owner = own_reg;
                        upd.ltime = req_reg.atime;
                        upd.prio  = req_reg.prize;
                        wr_en     = 1'b1;
                        wr_addr   = free_idx_reg;
                        wr_data   = upd;
                        cnt_tmp   = user_pages_reg[own_reg] + cti_pkg::cnt_t'(1);
                        free_pages_next          = free_pages_reg - cti_pkg::cnt_t'(1);
                        user_pages_next[own_reg] = cnt_tmp;
                        res_next.status = cti_pkg::STATUS_INSERTED;
                        res_next.page   = cti_pkg::page_t'(free_idx_reg);
                        res_next.block  = req_reg.block;
                        res_next.dirty  = req_reg.dirty;
                        res_next.user   = cti_pkg::own_to_user(own_reg);
                        res_next.count  = cti_pkg::ucount_t'(cnt_tmp);
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        // Free the chosen slot and drop its owner's count
                        upd.valid = 1'b0;
                        wr_en     = 1'b1;
                        wr_addr   = sel_idx_reg;
                        wr_data   = upd;
                        cnt_tmp   = user_pages_reg[sel_entry_reg.owner];
                        if (cnt_tmp != '0)
                        begin
                            cnt_tmp = cnt_tmp - cti_pkg::cnt_t'(1);
                        end
                        free_pages_next = free_pages_reg + cti_pkg::cnt_t'(1);
                        user_pages_next[sel_entry_reg.owner] = cnt_tmp;
                        res_next.status = cti_pkg::STATUS_EVICTED;
                        res_next.page   = cti_pkg::page_t'(sel_idx_reg);
                        res_next.block  = sel_entry_reg.tag;
                        res_next.dirty  = sel_entry_reg.dirty;
                        res_next.user   = cti_pkg::own_to_user(sel_entry_reg.owner);
                        res_next.count  = cti_pkg::ucount_t'(cnt_tmp);
                    end
                    else
                    begin
                        res_next.status = cti_pkg::STATUS_NOMATCH;
                    end
                end
            end

            ST_DONE:
            begin
                // Hold the result until the output register takes it
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_cnt_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            req_reg        <= '0;
            own_reg        <= '0;
            found_reg      <= 1'b0;
            sel_idx_reg    <= '0;
            sel_entry_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            free_pages_reg <= cti_pkg::cnt_t'(cti_pkg::PAGES);
            for (int u = 0; u < cti_pkg::USERS; u++)
            begin
                user_pages_reg[u] <= '0;
            end
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            chk_valid_reg  <= chk_valid_next;
            chk_idx_reg    <= chk_idx_next;
            req_reg        <= req_next;
            own_reg        <= own_next;
            found_reg      <= found_next;
            sel_idx_reg    <= sel_idx_next;
            sel_entry_reg  <= sel_entry_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            free_pages_reg <= free_pages_next;
            user_pages_reg <= user_pages_next;
            res_reg        <= res_next;
        end
    end

    // Total pages held by all users
    always_comb
    begin
        occ_sum = '0;
        for (int u = 0; u < cti_pkg::USERS; u++)
        begin
            occ_sum = occ_sum + cti_pkg::sum_t'(user_pages_reg[u]);
        end
    end

    // Free pages and held pages always add up to the table size
    `ASSERT_ALWAYS(a_page_balance, clk, rst_n, (cti_pkg::sum_t'(free_pages_reg) + occ_sum) == cti_pkg::sum_t'(cti_pkg::PAGES))
    // Memory is written only by the clear pass or a commit
    `ASSERT_IMPLY(a_write_phase, clk, rst_n, wr_en, (state_reg == ST_CLEAR) || (state_reg == ST_COMMIT))
    // The scan finds a free slot exactly when the free count is nonzero
    `ASSERT_IMPLY(a_free_track, clk, rst_n, (state_reg == ST_COMMIT) && (req_reg.op == cti_pkg::OP_INSERT) && !found_reg, free_found_reg == (free_pages_reg != '0))
    // A handed-off result is not offered twice
    `ASSERT_NEXT(a_single_handoff, clk, rst_n, res_valid && res_ready, !res_valid)

endmodule

@@ rtl/cache_table_insert_evict_core.sv @@
// Fully associative cache table with insert, hit update and oldest-by-priority evict
//
// Input items arrive on s_axis; s_axis_tuser selects insert (0) or evict (1) and
// s_axis_tdata carries block, dirty request, user, access time and priority.
// Each item gives exactly one result on m_axis; m_axis_tuser holds the status
// (inserted, hit, full, evicted, no match) and m_axis_tdata the slot and its fields.
// Every item scans all PAGES slots of the entry memory through its single read
// port, one slot per cycle, then commits at most one write, none for a full or
// no-match result. An item passes through scan, commit and done before its
// result goes to the output register; the next item is accepted right after.
// After reset the block sweeps the memory to invalidate every slot, one by one;
// s_axis_tready stays low until the sweep is done.
// A result waits in the output register while m_axis_tready is low; the block
// meanwhile accepts and scans the next item, and holds that item's result until
// the output register frees up.
module cache_table_insert_evict_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // disk_block[31:0], set_dirty[32], user[34:33], access_time[66:35],
    // prize[98:67], zero fill[103:99]
    input  logic [103:0]  s_axis_tdata,
    // operation[0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // page[9:0], entry_block[41:10], entry_dirty[42], entry_user[44:43],
    // user_count[55:45]
    output logic [55:0]   m_axis_tdata,
    // status[2:0]
    output logic [2:0]    m_axis_tuser
);

    cti_pkg::req_t     in_req;
    cti_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;

    logic                         rd_en;
    cti_pkg::idx_t                rd_addr;
    logic [cti_pkg::ENTRY_W-1:0]  rd_data;
    logic                         wr_en;
    cti_pkg::idx_t                wr_addr;
    logic [cti_pkg::ENTRY_W-1:0]  wr_data;

    logic              out_valid_reg, out_valid_next;
    cti_pkg::result_t  out_res_reg;

    // Unpack the input item
    always_comb
    begin
        in_req.op    = cti_pkg::op_t'(s_axis_tuser);
        in_req.block = s_axis_tdata[31:0];
        in_req.dirty = s_axis_tdata[32];
        in_req.user  = s_axis_tdata[34:33];
        in_req.atime = s_axis_tdata[66:35];
        in_req.prize = s_axis_tdata[98:67];
    end

    cti_ram #(
        .DEPTH  (cti_pkg::PAGES),
        .WIDTH  (cti_pkg::ENTRY_W),
        .ADDR_W (cti_pkg::IDX_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_ready ? res_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    // Pack the output item
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {out_res_reg.count, out_res_reg.user, out_res_reg.dirty,
                            out_res_reg.block, out_res_reg.page};

endmodule
